>>> design/mdsf_pkg.sv
// Shared types and constants for the minimum-density segment finder.
package mdsf_pkg;

    // Fixed field widths
    localparam int LEN_W = 11;   // min_length register
    localparam int IDX_W = 10;   // start_index / end_index result fields

    // Which comparison the shared compare engine is working on
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_BACK  = 2'd0;
    localparam t_mode MODE_FRONT = 2'd1;
    localparam t_mode MODE_BEST  = 2'd2;

    // Prefix memory read address select
    typedef logic [1:0] t_psel;
    localparam t_psel PSEL_START = 2'd0;
    localparam t_psel PSEL_P     = 2'd1;
    localparam t_psel PSEL_Q     = 2'd2;

    // Hull memory read address select: the older or the newer entry of a pair
    typedef logic t_hsel;
    localparam t_hsel HSEL_FIRST  = 1'b0;
    localparam t_hsel HSEL_SECOND = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic  accept;
        logic  step;
        logic  hull_rd;
        t_hsel hull_sel;
        logic  pre_rd;
        t_psel pre_sel;
        logic  cap_pstart;
        logic  cap_p;
        logic  cap_q;
        logic  cap_pp;
        logic  cap_pq;
        logic  load_ops;
        logic  mul1;
        logic  mul2;
        logic  pop_back;
        logic  pop_front;
        logic  push;
        logic  upd_best;
        logic  out_load;
        logic  clear;
        t_mode mode;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic count_ok;
        logic reached;
        logic ge2;
        logic lt;
        logic eq;
        logic have_best;
        logic last;
        logic out_free;
    } t_sts;

endpackage

>>> design/mdsf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module mdsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/mdsf_datapath.sv
// Datapath of the segment finder: prefix and hull memories, pointers, compare engine, result register.
module mdsf_datapath #(
    parameter int MAX_ITEMS  = 1024,
    parameter int SCORE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mdsf_pkg::t_cmd                      i_cmd,
    output mdsf_pkg::t_sts                      o_sts,
    input  logic                                i_cfg_we,
    input  logic [mdsf_pkg::LEN_W-1:0]          i_cfg_data,
    input  logic signed [SCORE_BITS-1:0]        i_score,
    input  logic                                i_last,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [mdsf_pkg::IDX_W-1:0]          o_start_index,
    output logic [mdsf_pkg::IDX_W-1:0]          o_end_index,
    output logic                                o_too_short
);

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = SCORE_BITS + IW;
    localparam int MW = PW + CW + 1;
    localparam int LW = mdsf_pkg::LEN_W;
    localparam int KW = (CW > LW) ? CW : LW;
    localparam int OW = mdsf_pkg::IDX_W;

    // Configuration and latched input beat
    logic [LW-1:0]                r_min_len;
    logic [LW-1:0]                r_act;
    logic signed [SCORE_BITS-1:0] r_score;
    logic                         r_last;

    // Sequence state
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_j1;
    logic [IW-1:0]        r_start;
    logic signed [PW-1:0] r_prefix;
    logic [CW-1:0]        r_front;
    logic [CW-1:0]        r_back;

    // Fetched candidates and compare engine
    logic [IW-1:0]        r_p;
    logic [IW-1:0]        r_q;
    logic signed [PW-1:0] r_pp;
    logic signed [PW-1:0] r_pq;
    logic signed [PW-1:0] r_pstart;
    logic                 r_pz;
    logic signed [PW-1:0] r_a;
    logic signed [PW-1:0] r_c;
    logic [CW-1:0]        r_b;
    logic [CW-1:0]        r_d;
    logic signed [MW-1:0] r_prod1;
    logic signed [MW-1:0] r_prod2;

    // Best segment so far
    logic                 r_have;
    logic signed [PW-1:0] r_best_sum;
    logic [CW-1:0]        r_best_len;
    logic [IW-1:0]        r_best_start;
    logic [IW-1:0]        r_best_end;

    // Result register
    logic          r_out_valid;
    logic [OW-1:0] r_o_start;
    logic [OW-1:0] r_o_end;
    logic          r_o_short;

    logic [LW-1:0]        act_now;
    logic [CW-1:0]        j1_now;
    logic [KW-1:0]        start_wide;
    logic signed [PW-1:0] prefix_now;
    logic                 count_ok;
    logic [CW-1:0]        pre_raddr;
    logic [PW-1:0]        pre_rdata;
    logic signed [PW-1:0] pre_eff;
    logic [CW-1:0]        hull_raddr_wide;
    logic [IW-1:0]        hull_rdata;
    logic signed [PW-1:0] n_a;
    logic signed [PW-1:0] n_c;
    logic [CW-1:0]        n_b;
    logic [CW-1:0]        n_d;
    logic signed [PW-1:0] mul_x;
    logic [CW-1:0]        mul_y;
    logic signed [MW-1:0] mul_x_ext;
    logic signed [MW-1:0] mul_y_ext;
    logic signed [MW-1:0] mul_p;
    logic                 out_free;

    // Active length is taken from the register at a sequence's first beat
    always_comb begin
        if (r_count == '0) begin
            act_now = (r_min_len == '0) ? LW'(1) : r_min_len;
        end else begin
            act_now = r_act;
        end
    end

    assign count_ok   = (r_count < CW'(MAX_ITEMS));
    assign j1_now     = r_count + CW'(1);
    assign start_wide = KW'(j1_now) - KW'(act_now);
    assign prefix_now = r_prefix + PW'(r_score);

    // Prefix memory
    always_comb begin
        case (i_cmd.pre_sel)
            mdsf_pkg::PSEL_START: pre_raddr = CW'(r_start);
            mdsf_pkg::PSEL_P:     pre_raddr = CW'(r_p);
            mdsf_pkg::PSEL_Q:     pre_raddr = CW'(r_q);
            default:              pre_raddr = CW'(r_start);
        endcase
    end

    mdsf_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_ITEMS + 1)
    ) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.step && count_ok),
        .i_waddr (j1_now),
        .i_wdata (prefix_now),
        .i_re    (i_cmd.pre_rd),
        .i_raddr (pre_raddr),
        .o_rdata (pre_rdata)
    );

    // Entry zero is never stored: it always reads as zero
    assign pre_eff = r_pz ? '0 : $signed(pre_rdata);

    // Hull memory
    always_comb begin
        if (i_cmd.mode == mdsf_pkg::MODE_BACK) begin
            hull_raddr_wide = (i_cmd.hull_sel == mdsf_pkg::HSEL_FIRST) ?
                              r_back - CW'(2) : r_back - CW'(1);
        end else begin
            hull_raddr_wide = (i_cmd.hull_sel == mdsf_pkg::HSEL_FIRST) ?
                              r_front : r_front + CW'(1);
        end
    end

    mdsf_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_ITEMS)
    ) u_hull_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_back[IW-1:0]),
        .i_wdata (r_start),
        .i_re    (i_cmd.hull_rd),
        .i_raddr (hull_raddr_wide[IW-1:0]),
        .o_rdata (hull_rdata)
    );

    // Compare operands: sign of a/b - c/d is the sign of a*d - c*b
    always_comb begin
        case (i_cmd.mode)
            mdsf_pkg::MODE_BACK: begin
                n_a = r_pq - r_pp;
                n_b = CW'(r_q) - CW'(r_p);
                n_c = r_pstart - r_pp;
                n_d = CW'(r_start) - CW'(r_p);
            end
            mdsf_pkg::MODE_FRONT: begin
                n_a = r_pq - r_pp;
                n_b = CW'(r_q) - CW'(r_p);
                n_c = r_prefix - r_pp;
                n_d = r_j1 - CW'(r_p);
            end
            mdsf_pkg::MODE_BEST: begin
                n_a = r_prefix - r_pp;
                n_b = r_j1 - CW'(r_p);
                n_c = r_best_sum;
                n_d = r_best_len;
            end
            default: begin
                n_a = r_pq - r_pp;
                n_b = CW'(r_q) - CW'(r_p);
                n_c = r_pstart - r_pp;
                n_d = CW'(r_start) - CW'(r_p);
            end
        endcase
    end

    // One shared multiplier, used for a*d then c*b
    assign mul_x     = i_cmd.mul2 ? r_c : r_a;
    assign mul_y     = i_cmd.mul2 ? r_b : r_d;
    assign mul_x_ext = MW'(mul_x);
    assign mul_y_ext = MW'($signed({1'b0, mul_y}));
    assign mul_p     = mul_x_ext * mul_y_ext;

    assign out_free = !r_out_valid || !i_out_stall;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len    <= LW'(1);
            r_act        <= LW'(1);
            r_count      <= '0;
            r_prefix     <= '0;
            r_front      <= '0;
            r_back       <= '0;
            r_have       <= 1'b0;
            r_best_sum   <= '0;
            r_best_len   <= '0;
            r_best_start <= '0;
            r_best_end   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_len <= i_cfg_data;
            end
            if (i_cmd.step && count_ok) begin
                r_prefix <= prefix_now;
                r_count  <= j1_now;
                if (r_count == '0) begin
                    r_act <= act_now;
                end
            end
            if (i_cmd.pop_back) begin
                r_back <= r_back - CW'(1);
            end
            if (i_cmd.push) begin
                r_back <= r_back + CW'(1);
            end
            if (i_cmd.pop_front) begin
                r_front <= r_front + CW'(1);
            end
            if (i_cmd.upd_best) begin
                r_have       <= 1'b1;
                r_best_sum   <= r_a;
                r_best_len   <= r_b;
                r_best_start <= r_p;
                r_best_end   <= IW'(r_j1 - CW'(1));
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_count      <= '0;
                r_prefix     <= '0;
                r_front      <= '0;
                r_back       <= '0;
                r_have       <= 1'b0;
                r_best_sum   <= '0;
                r_best_len   <= '0;
                r_best_start <= '0;
                r_best_end   <= '0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_score <= i_score;
            r_last  <= i_last;
        end
        if (i_cmd.step && count_ok) begin
            r_j1    <= j1_now;
            r_start <= start_wide[IW-1:0];
        end
        if (i_cmd.pre_rd) begin
            r_pz <= (pre_raddr == '0);
        end
        if (i_cmd.cap_pstart) begin
            r_pstart <= pre_eff;
        end
        if (i_cmd.cap_p) begin
            r_p <= hull_rdata;
        end
        if (i_cmd.cap_q) begin
            r_q <= hull_rdata;
        end
        if (i_cmd.cap_pp) begin
            r_pp <= pre_eff;
        end
        if (i_cmd.cap_pq) begin
            r_pq <= pre_eff;
        end
        if (i_cmd.load_ops) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
        end
        if (i_cmd.mul1) begin
            r_prod1 <= mul_p;
        end
        if (i_cmd.mul2) begin
            r_prod2 <= mul_p;
        end
        if (i_cmd.out_load) begin
            if (r_have) begin
                r_o_start <= OW'(r_best_start);
                r_o_end   <= OW'(r_best_end);
                r_o_short <= 1'b0;
            end else begin
                r_o_start <= '0;
                r_o_end   <= '0;
                r_o_short <= 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.count_ok  = count_ok;
        o_sts.reached   = (KW'(j1_now) >= KW'(act_now));
        o_sts.ge2       = ((r_back - r_front) >= CW'(2));
        o_sts.lt        = (r_prod1 < r_prod2);
        o_sts.eq        = (r_prod1 == r_prod2);
        o_sts.have_best = r_have;
        o_sts.last      = r_last;
        o_sts.out_free  = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_start_index = r_o_start;
    assign o_end_index   = r_o_end;
    assign o_too_short   = r_o_short;

endmodule

>>> design/mdsf_ctrl.sv
// Controller state machine of the segment finder: sequences memory reads, compares and hull updates.
module mdsf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mdsf_pkg::t_sts i_sts,
    output mdsf_pkg::t_cmd o_cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_STEP   = 5'd1;
    localparam logic [4:0] S_RSTART = 5'd2;
    localparam logic [4:0] S_CSTART = 5'd3;
    localparam logic [4:0] S_CHK    = 5'd4;
    localparam logic [4:0] S_F1     = 5'd5;
    localparam logic [4:0] S_F2     = 5'd6;
    localparam logic [4:0] S_F3     = 5'd7;
    localparam logic [4:0] S_F4     = 5'd8;
    localparam logic [4:0] S_OPS    = 5'd9;
    localparam logic [4:0] S_MUL1   = 5'd10;
    localparam logic [4:0] S_MUL2   = 5'd11;
    localparam logic [4:0] S_DEC    = 5'd12;
    localparam logic [4:0] S_PUSH   = 5'd13;
    localparam logic [4:0] S_BEST0  = 5'd14;
    localparam logic [4:0] S_BEST1  = 5'd15;
    localparam logic [4:0] S_BEST2  = 5'd16;
    localparam logic [4:0] S_BEST3  = 5'd17;
    localparam logic [4:0] S_FIN    = 5'd18;

    logic [4:0]      r_state;
    logic [4:0]      n_state;
    mdsf_pkg::t_mode r_mode;
    mdsf_pkg::t_mode n_mode;

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        o_cmd   = '0;
        o_cmd.mode = r_mode;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (i_sts.count_ok && i_sts.reached) begin
                    n_state = S_RSTART;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RSTART: begin
                o_cmd.pre_rd  = 1'b1;
                o_cmd.pre_sel = mdsf_pkg::PSEL_START;
                n_state       = S_CSTART;
            end
            S_CSTART: begin
                o_cmd.cap_pstart = 1'b1;
                n_mode           = mdsf_pkg::MODE_BACK;
                n_state          = S_CHK;
            end
            S_CHK: begin
                if (i_sts.ge2) begin
                    o_cmd.hull_rd  = 1'b1;
                    o_cmd.hull_sel = mdsf_pkg::HSEL_FIRST;
                    n_state        = S_F1;
                end else if (r_mode == mdsf_pkg::MODE_BACK) begin
                    n_state = S_PUSH;
                end else begin
                    n_state = S_BEST0;
                end
            end
            S_F1: begin
                o_cmd.cap_p    = 1'b1;
                o_cmd.hull_rd  = 1'b1;
                o_cmd.hull_sel = mdsf_pkg::HSEL_SECOND;
                n_state        = S_F2;
            end
            S_F2: begin
                o_cmd.cap_q   = 1'b1;
                o_cmd.pre_rd  = 1'b1;
                o_cmd.pre_sel = mdsf_pkg::PSEL_P;
                n_state       = S_F3;
            end
            S_F3: begin
                o_cmd.cap_pp  = 1'b1;
                o_cmd.pre_rd  = 1'b1;
                o_cmd.pre_sel = mdsf_pkg::PSEL_Q;
                n_state       = S_F4;
            end
            S_F4: begin
                o_cmd.cap_pq = 1'b1;
                n_state      = S_OPS;
            end
            S_OPS: begin
                o_cmd.load_ops = 1'b1;
                n_state        = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_DEC;
            end
            S_DEC: begin
                case (r_mode)
                    mdsf_pkg::MODE_BACK: begin
                        // drop the back entry while it no longer lies on the hull
                        if (i_sts.lt || i_sts.eq) begin
                            o_cmd.pop_back = 1'b1;
                            n_state        = S_CHK;
                        end else begin
                            n_state = S_PUSH;
                        end
                    end
                    mdsf_pkg::MODE_FRONT: begin
                        if (!i_sts.lt) begin
                            o_cmd.pop_front = 1'b1;
                            n_state         = S_CHK;
                        end else begin
                            n_state = S_BEST0;
                        end
                    end
                    default: begin
                        // strictly smaller average replaces the best; ties keep it
                        if (!i_sts.have_best || i_sts.lt) begin
                            o_cmd.upd_best = 1'b1;
                        end
                        n_state = S_FIN;
                    end
                endcase
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_mode     = mdsf_pkg::MODE_FRONT;
                n_state    = S_CHK;
            end
            S_BEST0: begin
                o_cmd.hull_rd  = 1'b1;
                o_cmd.hull_sel = mdsf_pkg::HSEL_FIRST;
                n_state        = S_BEST1;
            end
            S_BEST1: begin
                o_cmd.cap_p = 1'b1;
                n_state     = S_BEST2;
            end
            S_BEST2: begin
                o_cmd.pre_rd  = 1'b1;
                o_cmd.pre_sel = mdsf_pkg::PSEL_P;
                n_state       = S_BEST3;
            end
            S_BEST3: begin
                o_cmd.cap_pp = 1'b1;
                n_mode       = mdsf_pkg::MODE_BEST;
                n_state      = S_OPS;
            end
            S_FIN: begin
                if (!i_sts.last) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= mdsf_pkg::MODE_BACK;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> design/min_density_segment_finder.sv
// Top level of the minimum-density segment finder: controller plus datapath.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------------------
//   input    | i_in_valid / o_in_stall   | i_score (signed Q8.8), i_last
//   output   | o_out_valid / i_out_stall | o_start_index, o_end_index, o_too_short
//   config   | i_cfg_we                  | i_cfg_data (min_length)
//
// Beats are taken one at a time. A beat before min_length items have arrived, or
// beyond MAX_ITEMS, goes straight to the result check. Otherwise a beat runs the
// back pop loop, the push, the front pop loop and the best update; pops average
// at most one per beat and each loop ends on at most one failing comparison, so
// a beat averages at most three hull comparisons. The pace is set by the single
// shared multiplier and the one read port on each of the two memories.
// Reset: synchronous, active low; no clearing pass, memories are only read
// where written in the current sequence. A result waiting behind i_out_stall
// does not block new beats; only a second result holds the controller.
module min_density_segment_finder #(
    parameter int MAX_ITEMS  = 1024,
    parameter int SCORE_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [mdsf_pkg::LEN_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SCORE_BITS-1:0] i_score,
    input  logic                       i_last,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [mdsf_pkg::IDX_W-1:0] o_start_index,
    output logic [mdsf_pkg::IDX_W-1:0] o_end_index,
    output logic                       o_too_short
);

    // Commands down, status up: the only link between the two halves
    mdsf_pkg::t_cmd cmd;
    mdsf_pkg::t_sts sts;

    // Sequencer: back pops, push, front pops, best update, then result
    mdsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Prefix sums, hull deque, cross-multiply compare, result register
    mdsf_datapath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .SCORE_BITS (SCORE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_score       (i_score),
        .i_last        (i_last),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_start_index (o_start_index),
        .o_end_index   (o_end_index),
        .o_too_short   (o_too_short)
    );

endmodule

>>> bench/tb.sv
// Self-checking bench for min_density_segment_finder: score sequences in, best spans checked.
`timescale 1ns / 100ps

module tb;

    localparam int MAX_ITEMS      = 1024;
    localparam int SCORE_W        = 16;
    localparam int IDX_W          = mdsf_pkg::IDX_W;
    localparam int LEN_W          = mdsf_pkg::LEN_W;
    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_PCT       = 38;    // chance per cycle that a side sits idle
    localparam int HOLD_CYCLES    = 300;   // long output hold-off, fills the block
    localparam int SETTLE_CYCLES  = 40;    // quiet gap before a register write
    localparam int TAIL_CYCLES    = 200;   // watch for stray results at the end
    localparam int WATCHDOG_LIMIT = 40000; // limit on quiet cycles before the bench gives up
    localparam int ITEM_GOAL      = 1525;
    localparam int SPAN_GOAL      = 50;

    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

    // Shapes of a random score sequence
    typedef enum int {
        SHAPE_WIDE,
        SHAPE_NARROW,
        SHAPE_FLAT,
        SHAPE_TREND
    } t_shape;

    // One result beat
    typedef struct packed {
        logic [IDX_W-1:0] first_idx;
        logic [IDX_W-1:0] last_idx;
        logic             too_short;
    } t_span;

    // Tracks prefix sums and the hull of candidate starts, and checks result beats
    // against the spans it works out.
    class t_span_checker;
        longint      prefix_sum[];
        int unsigned hull_pos[];
        int unsigned hull_head, hull_tail, seen;
        longint      best_sum;
        int unsigned best_len, best_first, best_last;
        bit          have_best;
        int unsigned len_reg, len_live;
        t_span       expected_spans[$];
        int          failures, checked, beats;

        function new();
            prefix_sum = new[MAX_ITEMS + 1];
            hull_pos   = new[MAX_ITEMS];
            len_reg    = 1;
            len_live   = 1;
            failures   = 0;
            checked    = 0;
            beats      = 0;
            restart();
        endfunction

        function void restart();
            hull_head     = 0;
            hull_tail     = 0;
            seen          = 0;
            best_sum      = 0;
            best_len      = 0;
            best_first    = 0;
            best_last     = 0;
            have_best     = 1'b0;
            prefix_sum[0] = 0;
        endfunction

        function void write_min_length(logic [LEN_W-1:0] value);
            len_reg = value;
        endfunction

        function int pending();
            return expected_spans.size();
        endfunction

        // Sign of a/b - c/d with b, d > 0; products stay well inside 64 bits.
        function int avg_order(longint a, longint b, longint c, longint d);
            longint lhs, rhs;
            lhs = a * d;
            rhs = c * b;
            return (lhs < rhs) ? -1 : (lhs > rhs) ? 1 : 0;
        endfunction

        // Compare the average of items x..y with that of items u..v.
        function int span_order(int unsigned x, int unsigned y, int unsigned u,
                                int unsigned v);
            return avg_order(prefix_sum[y + 1] - prefix_sum[x], longint'(y) + 1 - longint'(x),
                             prefix_sum[v + 1] - prefix_sum[u], longint'(v) + 1 - longint'(u));
        endfunction

        function void note_score(logic signed [SCORE_W-1:0] score, logic last);
            int unsigned j, first, p, q, len;
            longint      sum;
            t_span       span;
            beats++;
            if (seen == 0) begin
                len_live      = (len_reg == 0) ? 1 : len_reg;
                prefix_sum[0] = 0;
            end
            if (seen < MAX_ITEMS) begin
                j                 = seen;
                prefix_sum[j + 1] = prefix_sum[j] + longint'(score);
                seen              = j + 1;
                if (j + 1 >= len_live) begin
                    first = j + 1 - len_live;
                    // drop back entries that the new start hides from the hull
                    while (hull_tail - hull_head >= 2) begin
                        p = hull_pos[hull_tail - 2];
                        q = hull_pos[hull_tail - 1];
                        if (span_order(p, q - 1, p, first - 1) <= 0) hull_tail--;
                        else break;
                    end
                    hull_pos[hull_tail] = first;
                    hull_tail++;
                    // advance the front while the next start gives no worse average
                    while (hull_tail - hull_head >= 2) begin
                        p = hull_pos[hull_head];
                        q = hull_pos[hull_head + 1];
                        if (span_order(p, q - 1, p, j) >= 0) hull_head++;
                        else break;
                    end
                    p   = hull_pos[hull_head];
                    sum = prefix_sum[j + 1] - prefix_sum[p];
                    len = j + 1 - p;
                    if (!have_best || avg_order(sum, len, best_sum, best_len) < 0) begin
                        have_best  = 1'b1;
                        best_sum   = sum;
                        best_len   = len;
                        best_first = p;
                        best_last  = j;
                    end
                end
            end
            if (last) begin
                span.first_idx = have_best ? best_first[IDX_W-1:0] : '0;
                span.last_idx  = have_best ? best_last[IDX_W-1:0] : '0;
                span.too_short = !have_best;
                expected_spans.insert(expected_spans.size(), span);
                restart();
            end
        endfunction

        function void check_span(t_span got);
            t_span want;
            if (expected_spans.size() == 0) begin
                $error("result with no sequence pending: start_index %0d end_index %0d %s %0d",
                       got.first_idx, got.last_idx, "too_short", got.too_short);
                failures++;
                return;
            end
            want = expected_spans.pop_front();
            checked++;
            if (got.first_idx !== want.first_idx) begin
                $error("start_index: expected %0d, got %0d", want.first_idx, got.first_idx);
                failures++;
            end
            if (got.last_idx !== want.last_idx) begin
                $error("end_index: expected %0d, got %0d", want.last_idx, got.last_idx);
                failures++;
            end
            if (got.too_short !== want.too_short) begin
                $error("too_short: expected %0d, got %0d", want.too_short, got.too_short);
                failures++;
            end
        endfunction
    endclass

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [LEN_W-1:0]          cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic signed [SCORE_W-1:0] score     = '0;
    logic                      last_flag = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [IDX_W-1:0]          start_index;
    logic [IDX_W-1:0]          end_index;
    logic                      too_short;

    t_span_checker sb;
    bit          calm      = 1'b0;  // both sides stop idling while set
    bit          hold_req  = 1'b0;  // asks the result side for its long hold-off
    bit          hold_done = 1'b0;
    int          spans_sent    = 0;
    int          beats_counted = 0;
    int          settings      = 0;

    min_density_segment_finder #(
        .MAX_ITEMS  (MAX_ITEMS),
        .SCORE_BITS (SCORE_W)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_score       (score),
        .i_last        (last_flag),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_start_index (start_index),
        .o_end_index   (end_index),
        .o_too_short   (too_short)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one score beat, with random idle cycles ahead of it, and hold it until taken.
    // Values seen at the edge are the ones from before it, so the handshake is
    // read exactly as the block sees it.
    task automatic send_beat(input logic signed [SCORE_W-1:0] value, input logic is_last);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        score     <= value;
        last_flag <= is_last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_score(value, is_last);
    endtask

    function automatic logic signed [SCORE_W-1:0] make_score(t_shape shape, int idx, int base,
                                                               int slope);
        int v;
        case (shape)
            SHAPE_WIDE:   v = int'($urandom_range(65535)) - 32768;
            SHAPE_NARROW: v = int'($urandom_range(600)) - 300;
            SHAPE_FLAT:   v = ($urandom_range(9) == 0) ? base - 1 : base;
            default:      v = base + idx * slope + int'($urandom_range(400)) - 200;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[SCORE_W-1:0];
    endfunction

    // Send one whole sequence; the final beat carries the last mark.
    task automatic send_sequence(input int unsigned n, input t_shape shape);
        int base, slope, i;
        base  = int'($urandom_range(2000)) - 1000;
        slope = int'($urandom_range(40)) - 20;
        for (i = 0; i < n; i++) send_beat(make_score(shape, i, base, slope), i == n - 1);
        spans_sent++;
        beats_counted += (n > MAX_ITEMS) ? MAX_ITEMS : n;
    endtask

    // Drain every pending result, let the block settle, then write min_length.
    task automatic set_min_length(input logic [LEN_W-1:0] value);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_min_length(value);
        settings++;
    endtask

    // Result side: check each accepted beat, then pick the stall for the next edge.
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) sb.check_span({start_index, end_index, too_short});
            if (hold_left > 0) begin
                // hold off in one long stretch so results back up into the input
                hold_left--;
                if (hold_left == 0) hold_done = 1'b1;
                out_stall <= 1'b1;
            end else if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Give up once no beat has moved on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
            else quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase, n;
        logic [LEN_W-1:0] len;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: score extremes at the reset length of one
        send_beat(SCORE_MIN, 1'b1);
        send_beat(SCORE_MAX, 1'b1);
        send_beat(SCORE_MAX, 1'b0);
        send_beat(SCORE_MIN, 1'b0);
        send_beat('0, 1'b1);
        // equal averages throughout: the earliest span must stand
        repeat (3) send_beat(16'sd5, 1'b0);
        send_beat(16'sd5, 1'b1);

        // a zero length behaves as one
        set_min_length('0);
        send_beat(-16'sd1, 1'b0);
        send_beat(-16'sd2, 1'b1);

        // register extremes: both sequences come up short
        set_min_length({LEN_W{1'b1}});
        send_beat(16'sd7, 1'b0);
        send_beat(-16'sd7, 1'b1);
        set_min_length(LEN_W'(MAX_ITEMS));
        send_beat(-16'sd3, 1'b1);

        // a sequence exactly min_length long, then one just under it
        set_min_length(LEN_W'(3));
        send_beat(16'sd100, 1'b0);
        send_beat(-16'sd50, 1'b0);
        send_beat(-16'sd50, 1'b1);
        send_beat(16'sd1, 1'b0);
        send_beat(16'sd2, 1'b1);

        // Random phases: a new min_length each, mostly short sequences
        phase = 0;
        while (beats_counted < ITEM_GOAL || spans_sent < SPAN_GOAL) begin
            case ($urandom_range(9))
                0:       len = '0;
                1:       len = LEN_W'($urandom_range(1024, 2047));
                2:       len = LEN_W'($urandom_range(13, 40));
                default: len = LEN_W'($urandom_range(1, 12));
            endcase
            if (phase == 2) len = LEN_W'($urandom_range(1, 700));
            set_min_length(len);
            calm = (phase >= 4 && phase < 7);
            if (phase == 1) begin
                // hold the results back while tiny sequences keep arriving
                hold_req = 1'b1;
                repeat (10) send_sequence($urandom_range(1, 3), t_shape'($urandom_range(3)));
            end else if (phase == 2) begin
                // run past MAX_ITEMS: the extra beats are dropped but the last mark counts
                send_sequence(MAX_ITEMS + $urandom_range(1, 6), t_shape'($urandom_range(3)));
            end else begin
                repeat (6) begin
                    n = ($urandom_range(7) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
                    send_sequence(n, t_shape'($urandom_range(3)));
                end
            end
            phase++;
        end

        // Wait out the remaining results, then watch for strays
        calm = 1'b0;
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d score beats over %0d min_length settings,",
                 sb.checked, sb.beats, settings);
        $display("zero, 1024 and all-ones lengths, one overlong sequence and a long output hold-off.");
        if (sb.failures == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
